[hw/rtl/mfps_pkg.sv]
// Shared types and constants for the masked frame pattern search.
`timescale 1ns / 1ps
`default_nettype none

package mfps_pkg;

    localparam int MAX_FIELDS_DEF      = 20;
    localparam int MAX_PATTERN_LEN_DEF = 44;
    localparam int MAX_BUFFER_LEN_DEF  = 4096;

    localparam int BYTE_W    = 8;
    localparam int FC_W      = 5;
    localparam int LEN_W     = 7;   // holds 2*31+4
    localparam int OFF_W     = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [FC_W-1:0]   FIELD_COUNT_RST    = 5'd1;
    localparam logic [BYTE_W-1:0] START_BYTE_RST     = 8'hFE;
    localparam logic [BYTE_W-1:0] SEPARATOR_BYTE_RST = 8'h00;
    localparam logic [BYTE_W-1:0] END_BYTE_RST       = 8'hEF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIELD_COUNT,
        CFG_START_BYTE,
        CFG_SEPARATOR_BYTE,
        CFG_END_BYTE
    } t_cfg_idx;

    typedef struct packed {
        logic [FC_W-1:0]   field_count;
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] separator_byte;
        logic [BYTE_W-1:0] end_byte;
    } t_cfg;

    typedef struct packed {
        logic             hit;
        logic [LEN_W-1:0] len_m1;
    } t_match_stat;

endpackage

`default_nettype wire

[hw/rtl/mfps_match.sv]
// Bit-parallel shift-and update of all partial matches for one byte.
`timescale 1ns / 1ps
`default_nettype none

module mfps_match #(
    parameter int MAX_FIELDS      = mfps_pkg::MAX_FIELDS_DEF,
    parameter int MAX_PATTERN_LEN = mfps_pkg::MAX_PATTERN_LEN_DEF
) (
    input  wire mfps_pkg::t_cfg              i_cfg,
    input  wire [mfps_pkg::BYTE_W-1:0]       i_data_byte,
    input  wire [MAX_PATTERN_LEN-1:0]        i_bits,
    output logic [MAX_PATTERN_LEN-1:0]       o_bits_next,
    output mfps_pkg::t_match_stat            o_stat
);

    localparam int LW = mfps_pkg::LEN_W;

    logic [LW-1:0]              len;
    logic [LW-1:0]              len_m1;
    logic                       usable;
    logic                       is_start;
    logic                       is_sep;
    logic                       is_end;
    logic [MAX_PATTERN_LEN-1:0] acc;
    logic [MAX_PATTERN_LEN-1:0] v;
    logic                       hit;

    assign len    = {1'b0, i_cfg.field_count, 1'b0} + LW'(4);
    assign len_m1 = len - LW'(1);
    assign usable = ({1'b0, i_cfg.field_count} <= (mfps_pkg::FC_W + 1)'(MAX_FIELDS)) &&
                    (len <= LW'(MAX_PATTERN_LEN));

    assign is_start = (i_data_byte == i_cfg.start_byte);
    assign is_sep   = (i_data_byte == i_cfg.separator_byte);
    assign is_end   = (i_data_byte == i_cfg.end_byte);

    // Per-position acceptance: start pair, end pair, wildcard on even, separator on odd.
    always_comb begin
        for (int p = 0; p < MAX_PATTERN_LEN; p++) begin
            if (LW'(p) >= len) begin
                acc[p] = 1'b0;
            end else if (p < 2) begin
                acc[p] = is_start;
            end else if ((LW + 1)'(p + 2) >= {1'b0, len}) begin
                acc[p] = is_end;
            end else if ((p % 2) == 0) begin
                acc[p] = 1'b1;
            end else begin
                acc[p] = is_sep;
            end
        end
    end

    assign v = {i_bits[MAX_PATTERN_LEN-2:0], 1'b1} & acc;

    always_comb begin
        hit = 1'b0;
        for (int p = 0; p < MAX_PATTERN_LEN; p++) begin
            if (LW'(p) == len_m1) begin
                hit = hit | v[p];
            end
        end
    end

    assign o_bits_next   = usable ? v : '0;
    assign o_stat.hit    = usable & hit;
    assign o_stat.len_m1 = len_m1;

endmodule

`default_nettype wire

[hw/rtl/masked_frame_pattern_search.sv]
// Top level of the masked frame pattern search: state, offsets and result buffering.
//
// Usage: bytes of a buffer enter on the input channel (i_valid / o_stall), one
// transaction per byte, with i_last_byte set on the final byte. For each buffer
// the block returns at most one result on the output channel (o_valid /
// i_stall): o_found = 1 with the start offset of the first frame that fits the
// pattern, or o_found = 0 and offset 0 when the last byte passes with no match.
// Bytes after a found frame are swallowed up to and including the last byte.
// A result is registered in the output register, or the skid register if that is held.
// Throughput: one byte per cycle unless o_stall is high; match update is combinational.
// A two-entry output buffer (output register plus skid register) absorbs a
// stalled receiver; o_stall rises only while both entries hold results.
// Reset clears the match state, the byte counter and the output buffer and
// loads the register defaults. Configuration writes are taken on any cycle
// with i_cfg_we high and apply from the next byte on.
`timescale 1ns / 1ps
`default_nettype none

module masked_frame_pattern_search #(
    parameter int MAX_FIELDS      = mfps_pkg::MAX_FIELDS_DEF,
    parameter int MAX_PATTERN_LEN = mfps_pkg::MAX_PATTERN_LEN_DEF,
    parameter int MAX_BUFFER_LEN  = mfps_pkg::MAX_BUFFER_LEN_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire [mfps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [mfps_pkg::BYTE_W-1:0]        i_cfg_data,
    input  wire                               i_valid,
    output logic                              o_stall,
    input  wire [mfps_pkg::BYTE_W-1:0]        i_data_byte,
    input  wire                               i_last_byte,
    output logic                              o_valid,
    input  wire                               i_stall,
    output logic                              o_found,
    output logic [mfps_pkg::OFF_W-1:0]        o_start_offset
);

    localparam int POS_W  = $clog2(MAX_BUFFER_LEN);
    localparam int OFF_W  = mfps_pkg::OFF_W;
    localparam int CALC_W = (POS_W > OFF_W) ? POS_W : OFF_W;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_BUFFER_LEN - 1);

    mfps_pkg::t_cfg              r_cfg;
    logic [MAX_PATTERN_LEN-1:0]  r_bits;
    logic [POS_W-1:0]            r_pos;
    logic                        r_done;
    logic                        r_out_valid;
    logic                        r_out_found;
    logic [OFF_W-1:0]            r_out_offset;
    logic                        r_skid_valid;
    logic                        r_skid_found;
    logic [OFF_W-1:0]            r_skid_offset;

    logic [MAX_PATTERN_LEN-1:0]  n_bits;
    mfps_pkg::t_match_stat       stat;
    logic                        accept;
    logic                        out_take;
    logic                        res_valid;
    logic                        res_found;
    logic [OFF_W-1:0]            res_offset;
    logic [CALC_W-1:0]           diff;

    mfps_match #(
        .MAX_FIELDS      (MAX_FIELDS),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_match (
        .i_cfg       (r_cfg),
        .i_data_byte (i_data_byte),
        .i_bits      (r_bits),
        .o_bits_next (n_bits),
        .o_stat      (stat)
    );

    assign o_stall  = r_skid_valid;
    assign accept   = i_valid & ~r_skid_valid;
    assign out_take = r_out_valid & ~i_stall;
    assign diff     = CALC_W'(r_pos) - CALC_W'(stat.len_m1);

    // Result of the accepted byte: found on a completed frame, not-found on a dry last byte.
    always_comb begin
        res_valid  = 1'b0;
        res_found  = 1'b0;
        res_offset = '0;
        if (accept && !r_done) begin
            if (stat.hit) begin
                res_valid  = 1'b1;
                res_found  = 1'b1;
                res_offset = diff[OFF_W-1:0];
            end else if (i_last_byte) begin
                res_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.field_count    <= mfps_pkg::FIELD_COUNT_RST;
            r_cfg.start_byte     <= mfps_pkg::START_BYTE_RST;
            r_cfg.separator_byte <= mfps_pkg::SEPARATOR_BYTE_RST;
            r_cfg.end_byte       <= mfps_pkg::END_BYTE_RST;
        end else if (i_cfg_we) begin
            case (mfps_pkg::t_cfg_idx'(i_cfg_index))
                mfps_pkg::CFG_FIELD_COUNT:    r_cfg.field_count    <= i_cfg_data[mfps_pkg::FC_W-1:0];
                mfps_pkg::CFG_START_BYTE:     r_cfg.start_byte     <= i_cfg_data;
                mfps_pkg::CFG_SEPARATOR_BYTE: r_cfg.separator_byte <= i_cfg_data;
                mfps_pkg::CFG_END_BYTE:       r_cfg.end_byte       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
            r_pos  <= '0;
            r_done <= 1'b0;
        end else if (accept) begin
            if (i_last_byte) begin
                // start the next buffer afresh
                r_bits <= '0;
                r_pos  <= '0;
                r_done <= 1'b0;
            end else if (!r_done) begin
                r_bits <= n_bits;
                r_done <= stat.hit;
                if (r_pos < POS_MAX) begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // no transaction enters while the skid holds; drain it forward
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out_found  <= r_skid_found;
                r_out_offset <= r_skid_offset;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_take) begin
                r_out_found  <= res_found;
                r_out_offset <= res_offset;
            end else begin
                r_skid_found  <= res_found;
                r_skid_offset <= res_offset;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_found        = r_out_found;
    assign o_start_offset = r_out_offset;

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench for masked_frame_pattern_search: directed cases, then random buffers.
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_FIELDS      = mfps_pkg::MAX_FIELDS_DEF;
    localparam int MAX_PATTERN_LEN = mfps_pkg::MAX_PATTERN_LEN_DEF;
    localparam int POS_MAX         = mfps_pkg::MAX_BUFFER_LEN_DEF - 1;
    localparam int BYTE_W          = mfps_pkg::BYTE_W;
    localparam int FC_W            = mfps_pkg::FC_W;
    localparam int OFF_W           = mfps_pkg::OFF_W;
    localparam int SETTLE_CYCLES   = 4;
    localparam int PHASE_BYTES     = 30;

    typedef struct packed {
        logic             found;
        logic [OFF_W-1:0] offset;
    } t_search_result;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_we = 1'b0;
    mfps_pkg::t_cfg_idx   cfg_index = mfps_pkg::CFG_FIELD_COUNT;
    logic [BYTE_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic [BYTE_W-1:0]    in_data = '0;
    logic                 in_last = 1'b0;
    logic                 rx_stall = 1'b0;

    logic              o_stall;
    logic              o_valid;
    logic              o_found;
    logic [OFF_W-1:0]  o_start_offset;

    masked_frame_pattern_search u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_valid        (in_valid),
        .o_stall        (o_stall),
        .i_data_byte    (in_data),
        .i_last_byte    (in_last),
        .o_valid        (o_valid),
        .i_stall        (rx_stall),
        .o_found        (o_found),
        .o_start_offset (o_start_offset)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state and its copy of the registers
    mfps_pkg::t_cfg model_cfg = '{mfps_pkg::FIELD_COUNT_RST, mfps_pkg::START_BYTE_RST,
                                  mfps_pkg::SEPARATOR_BYTE_RST, mfps_pkg::END_BYTE_RST};
    logic [MAX_PATTERN_LEN-1:0] match_vec = '0;
    logic [OFF_W-1:0]           byte_pos = '0;
    logic                       frame_seen = 1'b0;

    t_search_result expected_outcomes[$];
    logic [BYTE_W-1:0] buf_q[$];

    int err_count = 0;
    int bytes_searched = 0;
    int frames_found = 0;
    int frames_missed = 0;
    int configs_loaded = 0;
    int burst_left = 0;
    bit hold_req = 1'b0;
    bit hold_active = 1'b0;
    int hold_len = 0;

    // Positions of the pattern that accept byte b
    function automatic logic [MAX_PATTERN_LEN-1:0] accept_mask(input logic [BYTE_W-1:0] b,
                                                               input int len);
        logic [MAX_PATTERN_LEN-1:0] m;
        m = '0;
        for (int p = 0; p < MAX_PATTERN_LEN; p++) begin
            if (p < len) begin
                if (p < 2)
                    m[p] = (b == model_cfg.start_byte);
                else if (p + 2 >= len)
                    m[p] = (b == model_cfg.end_byte);
                else if (p % 2 == 0)
                    m[p] = 1'b1;
                else
                    m[p] = (b == model_cfg.separator_byte);
            end
        end
        return m;
    endfunction

    task automatic restart_search();
        match_vec  = '0;
        byte_pos   = '0;
        frame_seen = 1'b0;
    endtask

    task automatic predict_search_byte(input logic [BYTE_W-1:0] b, input logic last);
        int len;
        logic hit;
        logic [MAX_PATTERN_LEN-1:0] v;
        t_search_result r;
        len = 2 * int'(model_cfg.field_count) + 4;
        hit = 1'b0;
        // swallow everything after a hit up to the buffer end
        if (frame_seen) begin
            if (last)
                restart_search();
            return;
        end
        bytes_searched++;
        if (int'(model_cfg.field_count) <= MAX_FIELDS && len <= MAX_PATTERN_LEN) begin
            v = ((match_vec << 1) | 1) & accept_mask(b, len);
            match_vec = v;
            if (v[len-1]) begin
                r.found  = 1'b1;
                r.offset = byte_pos - OFF_W'(len - 1);
                expected_outcomes.push_back(r);
                hit = 1'b1;
                frame_seen = 1'b1;
                frames_found++;
            end
        end else begin
            match_vec = '0;
        end
        if (byte_pos < POS_MAX)
            byte_pos++;
        if (last) begin
            if (!hit) begin
                r.found  = 1'b0;
                r.offset = '0;
                expected_outcomes.push_back(r);
                frames_missed++;
            end
            restart_search();
        end
    endtask

    // Offer one byte and hold it until the block takes it
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        in_valid <= 1'b1;
        in_data  <= b;
        in_last  <= last;
        @(posedge clk);
        while (o_stall)
            @(posedge clk);
        predict_search_byte(b, last);
    endtask

    task automatic idle_gap(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Drop valid and wait until every expected result is in, plus the output latency
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_config(input logic [FC_W-1:0] fc, input logic [BYTE_W-1:0] sb,
                               input logic [BYTE_W-1:0] sp, input logic [BYTE_W-1:0] eb);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= mfps_pkg::CFG_FIELD_COUNT;
        cfg_data  <= BYTE_W'(fc);
        @(posedge clk);
        cfg_index <= mfps_pkg::CFG_START_BYTE;
        cfg_data  <= sb;
        @(posedge clk);
        cfg_index <= mfps_pkg::CFG_SEPARATOR_BYTE;
        cfg_data  <= sp;
        @(posedge clk);
        cfg_index <= mfps_pkg::CFG_END_BYTE;
        cfg_data  <= eb;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        model_cfg = '{fc, sb, sp, eb};
        configs_loaded++;
    endtask

    task automatic pace();
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0)
                idle_gap($urandom_range(1, 5));
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Send the queued buffer, last-byte mark on its final byte
    task automatic flush_buffer(input bit paced);
        for (int i = 0; i < buf_q.size(); i++) begin
            send_byte(buf_q[i], i == buf_q.size() - 1);
            if (paced)
                pace();
        end
        buf_q.delete();
    endtask

    task automatic push_hex(input logic [63:0] w, input int n);
        for (int i = n - 1; i >= 0; i--)
            buf_q.push_back(w[8*i +: 8]);
    endtask

    // Bias toward the register values so partial matches happen often
    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 4))
            0:       return model_cfg.start_byte;
            1:       return model_cfg.separator_byte;
            2:       return model_cfg.end_byte;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_noise(input int n);
        repeat (n) buf_q.push_back(pick_byte());
    endtask

    task automatic push_frame(input bit broken);
        int base;
        int len;
        base = buf_q.size();
        len  = 2 * int'(model_cfg.field_count) + 4;
        buf_q.push_back(model_cfg.start_byte);
        buf_q.push_back(model_cfg.start_byte);
        repeat (int'(model_cfg.field_count)) begin
            buf_q.push_back(BYTE_W'($urandom_range(0, 255)));
            buf_q.push_back(model_cfg.separator_byte);
        end
        buf_q.push_back(model_cfg.end_byte);
        buf_q.push_back(model_cfg.end_byte);
        if (broken)
            buf_q[base + $urandom_range(0, len - 1)] = BYTE_W'($urandom_range(0, 255));
    endtask

    // Reset values: a frame with trailing ignored bytes, and the two reference strings
    task automatic test_default_config();
        buf_q.push_back(8'h00);
        push_frame(1'b0);
        push_hex(64'h3344, 2);
        flush_buffer(1'b0);
        push_hex(64'hFEFE_0000_EFEF, 6);
        flush_buffer(1'b0);
        push_hex(64'hFFFF_00FF_FFFF, 6);
        flush_buffer(1'b0);
    endtask

    task automatic test_zero_fields();
        load_config(5'd0, 8'h00, 8'hFF, 8'hFF);
        push_hex(64'h00_0000_FFFF, 5);
        flush_buffer(1'b0);
        load_config(5'd0, 8'hFF, 8'h00, 8'hFF);
        push_hex(64'hFFFF_FFFF_FF00, 6);
        flush_buffer(1'b0);
    endtask

    // Largest usable pattern, then field counts past the limit
    task automatic test_field_limits();
        load_config(5'd20, 8'hFF, 8'hFF, 8'h00);
        push_frame(1'b0);
        flush_buffer(1'b0);
        load_config(5'd21, 8'hFF, 8'hFF, 8'h00);
        push_frame(1'b0);
        flush_buffer(1'b0);
        load_config(5'd31, 8'h00, 8'h00, 8'h00);
        push_hex(64'h0, 8);
        flush_buffer(1'b0);
    endtask

    // Buffers shorter than the pattern, and a frame behind an extra start byte
    task automatic test_short_buffer();
        load_config(5'd2, 8'hAA, 8'h55, 8'hCC);
        push_hex(64'hAAAA55, 3);
        flush_buffer(1'b0);
        push_hex(64'hAA, 1);
        flush_buffer(1'b0);
        buf_q.push_back(8'hAA);
        push_frame(1'b0);
        flush_buffer(1'b0);
    endtask

    // Receiver holds off while short buffers keep coming, then the sender drains
    task automatic test_backpressure();
        load_config(5'd0, 8'hFE, 8'h00, 8'hEF);
        hold_len = 200;
        hold_req = 1'b1;
        wait (hold_active);
        repeat (12) begin
            push_frame(1'b0);
            flush_buffer(1'b0);
            buf_q.push_back(BYTE_W'($urandom_range(0, 255)));
            flush_buffer(1'b0);
        end
        settle();
    endtask

    task automatic test_random();
        int target;
        int roll;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: load_config(5'd0, 8'h00, 8'h00, 8'hFF);
                1: load_config(5'd20, 8'hFF, 8'hFF, 8'h00);
                2: load_config(FC_W'($urandom_range(21, 31)), BYTE_W'($urandom),
                               BYTE_W'($urandom), BYTE_W'($urandom));
                default: load_config(($urandom_range(0, 5) == 0) ? FC_W'($urandom_range(0, 31))
                                                                 : FC_W'($urandom_range(0, 4)),
                                     BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
            endcase
            target = bytes_searched + PHASE_BYTES;
            while (bytes_searched < target) begin
                roll = $urandom_range(0, 9);
                if (roll < 7) begin
                    push_noise($urandom_range(0, 4));
                    push_frame($urandom_range(0, 3) == 0);
                    push_noise($urandom_range(0, 3));
                end else begin
                    push_noise($urandom_range(1, 12));
                end
                flush_buffer(1'b1);
                if ($urandom_range(0, 15) == 0)
                    settle();
            end
        end
    endtask

    // Receiver stall pattern: random runs, quiet stretches, and long holds on request
    initial begin
        int n;
        @(posedge clk);
        forever begin
            if (hold_req) begin
                rx_stall <= 1'b1;
                hold_active = 1'b1;
                repeat (hold_len) @(posedge clk);
                hold_active = 1'b0;
                hold_req = 1'b0;
            end else begin
                n = $urandom_range(1, 8);
                case ($urandom_range(0, 7))
                    0: begin
                        rx_stall <= 1'b0;
                        n = $urandom_range(20, 60);
                    end
                    1, 2: rx_stall <= 1'b1;
                    default: rx_stall <= 1'b0;
                endcase
                repeat (n) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin : check_results
        t_search_result want;
        if (rst_n && o_valid && !rx_stall) begin
            if (expected_outcomes.size() == 0) begin
                $error("unexpected result: found=%0d start_offset=%0d", o_found, o_start_offset);
                err_count++;
            end else begin
                want = expected_outcomes.pop_front();
                if (o_found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_found);
                    err_count++;
                end
                if (o_start_offset !== want.offset) begin
                    $error("start_offset: expected %0d, got %0d", want.offset, o_start_offset);
                    err_count++;
                end
            end
        end
    end

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_config();
        test_zero_fields();
        test_field_limits();
        test_short_buffer();
        test_backpressure();
        test_random();
        settle();
        $display("tb_top: %0d bytes searched, %0d frames found, %0d buffers without a match",
                 bytes_searched, frames_found, frames_missed);
        $display("tb_top: %0d register loads, field counts 0..31, full block under hold-off",
                 configs_loaded);
        if (err_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/mfps_pkg.sv
hw/rtl/mfps_match.sv
hw/rtl/masked_frame_pattern_search.sv
bench/tb_top.sv
